// ----- hdl/rbf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rbf_pkg;

  localparam int ChanW   = 8;
  localparam int CoordW  = 10;
  localparam int CfgW    = 11;
  localparam int SumW    = 12;   // nine 8-bit values, max 2295
  localparam int RecipW  = 13;
  localparam int RecipSh = 16;
  // ceil(2^16 / 9); exact floor for every sum below 2^12
  localparam logic [RecipW-1:0] Recip9 = 13'd7282;

  localparam int RegIdxW = 1;
  localparam logic [RegIdxW-1:0] RegWidth  = 1'b0;
  localparam logic [RegIdxW-1:0] RegHeight = 1'b1;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    pixel_t upper;
    pixel_t middle;
  } line_pair_t;

  typedef struct packed {
    logic [SumW-1:0] red;
    logic [SumW-1:0] green;
    logic [SumW-1:0] blue;
  } sum_t;

  function automatic logic [ChanW-1:0] div9(input logic [SumW-1:0] s);
    logic [SumW+RecipW-1:0] p;
    p = (SumW+RecipW)'(s) * (SumW+RecipW)'(Recip9);
    return p[RecipSh+ChanW-1:RecipSh];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/rgb_box_filter_3x3_top.sv -----
// 3x3 box filter on an RGB raster stream.
// Input channel: one pixel word per accepted cycle (in_valid_i high, in_stall_o
// low), red/green/blue, in raster order. Output channel: one word per interior
// pixel with the truncated 3x3 mean of each channel, the center's column and
// row, and frame_end on the last interior pixel. Border pixels give no word.
// Frame size comes from the image_width (0x0) and image_height (0x4) registers,
// clamped to 3..MAX; writing either restarts the frame at column 0, row 0.
// Throughput is one pixel per clock while in_stall_o is low, set by
// the single-port-per-side line buffer: read at acceptance, written back
// one stage later. The pipeline has three register stages (line buffer read,
// window sum, divide by 9), through which each accepted pixel moves in order.
// Reset clears the counters and pipeline valids and sets both dimensions to
// 1024; line buffer contents stay undefined until the rows are streamed in.
// When out_stall_i holds a word, the result register keeps it and the stages
// behind it fill; in_stall_o rises once the input stage cannot move.
`timescale 1ns / 1ps
`default_nettype none

module rgb_box_filter_3x3_top import rbf_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [ChanW-1:0]  in_red_i,
  input  wire logic [ChanW-1:0]  in_green_i,
  input  wire logic [ChanW-1:0]  in_blue_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [ChanW-1:0]  out_red_o,
  output logic      [ChanW-1:0]  out_green_o,
  output logic      [ChanW-1:0]  out_blue_o,
  output logic      [CoordW-1:0] center_col_o,
  output logic      [CoordW-1:0] center_row_o,
  output logic                   frame_end_o
);

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int RowW  = $clog2(MAX_HEIGHT);
  localparam int WDimW = $clog2(MAX_WIDTH + 1);
  localparam int HDimW = $clog2(MAX_HEIGHT + 1);
  localparam int CmpWW = (WDimW > CfgW) ? WDimW : CfgW;
  localparam int CmpHW = (HDimW > CfgW) ? HDimW : CfgW;

  // configuration
  logic [CfgW-1:0]    width_q, height_q;
  logic               cfg_wr;
  logic [RegIdxW-1:0] reg_idx;
  logic [CmpWW-1:0]   w_eff;
  logic [CmpHW-1:0]   h_eff;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      RegWidth:  prdata = 32'(width_q);
      RegHeight: prdata = 32'(height_q);
      default:   prdata = '0;
    endcase
  end

  always_comb begin
    priority if (CmpWW'(width_q) < CmpWW'(3)) begin
      w_eff = CmpWW'(3);
    end else if (CmpWW'(width_q) > CmpWW'(MAX_WIDTH)) begin
      w_eff = CmpWW'(MAX_WIDTH);
    end else begin
      w_eff = CmpWW'(width_q);
    end
    priority if (CmpHW'(height_q) < CmpHW'(3)) begin
      h_eff = CmpHW'(3);
    end else if (CmpHW'(height_q) > CmpHW'(MAX_HEIGHT)) begin
      h_eff = CmpHW'(MAX_HEIGHT);
    end else begin
      h_eff = CmpHW'(height_q);
    end
  end

  // pipeline control
  logic in_acc, a_adv, a_ready, b_adv, b_ready, out_ready;
  logic a_valid_q, b_valid_q, out_valid_q;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign b_adv      = b_valid_q && out_ready;
  assign b_ready    = !b_valid_q || out_ready;
  assign a_adv      = a_valid_q && b_ready;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_stall_o = !a_ready;
  assign in_acc     = in_valid_i && a_ready;

  // raster counters
  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  logic              col_last, row_last, emit;
  logic [31:0]       ccol_ext, crow_ext;

  always_comb begin
    col_last = (CmpWW'(col_q) == w_eff - CmpWW'(1));
    row_last = (CmpHW'(row_q) == h_eff - CmpHW'(1));
    emit     = (col_q >= ColW'(2)) && (row_q >= RowW'(2));
    ccol_ext = 32'(col_q - ColW'(1));
    crow_ext = 32'(row_q - RowW'(1));
    col_d    = col_last ? '0 : col_q + ColW'(1);
    row_d    = row_q;
    if (col_last) begin
      row_d = row_last ? '0 : row_q + RowW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(1024);
      height_q <= CfgW'(1024);
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegWidth:  width_q  <= pwdata[CfgW-1:0];
        RegHeight: height_q <= pwdata[CfgW-1:0];
        default:   ;
      endcase
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage A: pixel and line buffer read
  pixel_t            a_px_q;
  logic [ColW-1:0]   a_col_q;
  logic              a_emit_q, a_fend_q;
  logic [CoordW-1:0] a_ccol_q, a_crow_q;
  line_pair_t        rd_data, wr_data;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_px_q   <= '{red: in_red_i, green: in_green_i, blue: in_blue_i};
      a_col_q  <= col_q;
      a_emit_q <= emit;
      a_fend_q <= col_last && row_last;
      a_ccol_q <= ccol_ext[CoordW-1:0];
      a_crow_q <= crow_ext[CoordW-1:0];
    end
  end

  assign wr_data = '{upper: rd_data.middle, middle: a_px_q};

  rbf_line_buf #(
    .Depth (MAX_WIDTH),
    .AddrW (ColW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_q),
    .rd_data_o (rd_data),
    .wr_en_i   (a_adv),
    .wr_addr_i (a_col_q),
    .wr_data_i (wr_data)
  );

  // stage B: window sums
  sum_t              b_sum;
  logic              b_fend_q;
  logic [CoordW-1:0] b_ccol_q, b_crow_q;

  rbf_window u_window (
    .clk_i (clk_i),
    .en_i  (a_adv),
    .top_i (rd_data.upper),
    .mid_i (rd_data.middle),
    .px_i  (a_px_q),
    .sum_o (b_sum)
  );

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_fend_q <= a_fend_q;
      b_ccol_q <= a_ccol_q;
      b_crow_q <= a_crow_q;
    end
  end

  // stage C: divide by 9 into the result register
  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      out_red_o    <= div9(b_sum.red);
      out_green_o  <= div9(b_sum.green);
      out_blue_o   <= div9(b_sum.blue);
      center_col_o <= b_ccol_q;
      center_row_o <= b_crow_q;
      frame_end_o  <= b_fend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_acc;
      end
      if (b_ready) begin
        b_valid_q <= a_adv && a_emit_q;
      end
      if (out_ready) begin
        out_valid_q <= b_adv;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpWW'(col_q) < w_eff)
    else $error("column counter beyond frame width");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpHW'(row_q) < h_eff)
    else $error("row counter beyond frame height");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> a_valid_q && b_valid_q && out_valid_q)
    else $error("input stalled with an empty stage");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(b_valid_q))
    else $error("result word without a window sum behind it");

endmodule

`default_nettype wire

// ----- hdl/rbf_line_buf.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rbf_line_buf import rbf_pkg::*; #(
  parameter int Depth = 1024,
  parameter int AddrW = 10
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output line_pair_t            rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire line_pair_t       wr_data_i
);

  line_pair_t mem_q [Depth];
  line_pair_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

// ----- hdl/rbf_window.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rbf_window import rbf_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   en_i,
  input  wire pixel_t top_i,
  input  wire pixel_t mid_i,
  input  wire pixel_t px_i,
  output sum_t        sum_o
);

  // two previous columns of the 3-row band, oldest first
  pixel_t win_q [6];
  pixel_t taps  [9];
  sum_t   sum_d;
  sum_t   sum_q;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      taps[i] = win_q[i];
    end
    taps[6] = top_i;
    taps[7] = mid_i;
    taps[8] = px_i;
    sum_d = '0;
    for (int i = 0; i < 9; i++) begin
      sum_d.red   = sum_d.red   + SumW'(taps[i].red);
      sum_d.green = sum_d.green + SumW'(taps[i].green);
      sum_d.blue  = sum_d.blue  + SumW'(taps[i].blue);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top_i;
      win_q[4] <= mid_i;
      win_q[5] <= px_i;
      sum_q    <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire
